>>> rtl/core/cmpf_pkg.sv
// package for the cube map pixel to face unit: codes, widths and register indexes
`default_nettype none
package cmpf_pkg;
    localparam int COORD_BITS = 14;
    localparam int RES_BITS   = 13;
    localparam int FRAC_BITS  = 16;
    localparam int FACE_BITS  = 3;
    localparam int OUT_BITS   = 16;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 13;
    localparam int NUM_REGS   = 8;

    typedef enum logic [FACE_BITS-1:0] {
        FACE_FRONT  = 3'd0,
        FACE_BACK   = 3'd1,
        FACE_LEFT   = 3'd2,
        FACE_RIGHT  = 3'd3,
        FACE_TOP    = 3'd4,
        FACE_BOTTOM = 3'd5,
        FACE_NONE   = 3'd6
    } t_face;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_RES_FRONT  = 3'd0,
        REG_RES_BACK   = 3'd1,
        REG_RES_LEFT   = 3'd2,
        REG_RES_RIGHT  = 3'd3,
        REG_RES_TOP    = 3'd4,
        REG_RES_BOTTOM = 3'd5,
        REG_COL_WIDTH  = 3'd6,
        REG_BAND_HT    = 3'd7
    } t_reg_idx;

    localparam logic [RES_BITS-1:0] RES_RESET = RES_BITS'(512);
endpackage
`default_nettype wire

>>> rtl/core/cmpf_geom.sv
// face geometry: start coordinates of the six faces from the configuration registers
`default_nettype none
module cmpf_geom #(
    parameter int RES_BITS = cmpf_pkg::RES_BITS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [cmpf_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [RES_BITS-1:0] i_cfg_data,
    output logic                     o_busy,
    output logic [6*RES_BITS-1:0]    o_res,
    output logic [6*(RES_BITS+2)-1:0] o_si,
    output logic [6*(RES_BITS+2)-1:0] o_sj
);
    localparam int SW = RES_BITS + 2;

    logic [RES_BITS-1:0] r_res [6];
    logic [RES_BITS-1:0] r_col, r_band;
    logic [SW-1:0] r_si [6];
    logic [SW-1:0] r_sj [6];
    logic [SW-1:0] n_si [6];
    logic [SW-1:0] n_sj [6];
    logic [RES_BITS-1:0] w_data;
    logic r_busy;

    function automatic logic [RES_BITS-1:0] margin(input logic [RES_BITS-1:0] span,
                                                   input logic [RES_BITS-1:0] res);
        logic [RES_BITS-1:0] d;
        begin
            d = span - res;
            margin = (span > res) ? {1'b0, d[RES_BITS-1:1]} : '0;
        end
    endfunction

    assign o_cfg_ready = 1'b1;
    assign w_data = RES_BITS'(i_cfg_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) r_res[k] <= cmpf_pkg::RES_RESET;
            r_col  <= cmpf_pkg::RES_RESET;
            r_band <= cmpf_pkg::RES_RESET;
        end else if (i_cfg_valid) begin
            unique case (cmpf_pkg::t_reg_idx'(i_cfg_index))
                cmpf_pkg::REG_RES_FRONT:  r_res[cmpf_pkg::FACE_FRONT]  <= w_data;
                cmpf_pkg::REG_RES_BACK:   r_res[cmpf_pkg::FACE_BACK]   <= w_data;
                cmpf_pkg::REG_RES_LEFT:   r_res[cmpf_pkg::FACE_LEFT]   <= w_data;
                cmpf_pkg::REG_RES_RIGHT:  r_res[cmpf_pkg::FACE_RIGHT]  <= w_data;
                cmpf_pkg::REG_RES_TOP:    r_res[cmpf_pkg::FACE_TOP]    <= w_data;
                cmpf_pkg::REG_RES_BOTTOM: r_res[cmpf_pkg::FACE_BOTTOM] <= w_data;
                cmpf_pkg::REG_COL_WIDTH:  r_col  <= w_data;
                cmpf_pkg::REG_BAND_HT:    r_band <= w_data;
                default: ;
            endcase
        end
    end

    // starts lag the registers, settling in the cycle after a write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_busy <= 1'b0;
        else r_busy <= i_cfg_valid;
    end
    assign o_busy = r_busy;

    always_comb begin
        logic [SW-1:0] l, t, c, b;
        l = SW'(r_res[cmpf_pkg::FACE_LEFT]);
        t = SW'(r_res[cmpf_pkg::FACE_TOP]);
        c = SW'(r_col);
        b = SW'(r_band);
        n_si[cmpf_pkg::FACE_LEFT]   = '0;
        n_sj[cmpf_pkg::FACE_LEFT]   = t + SW'(margin(r_band, r_res[cmpf_pkg::FACE_LEFT]));
        n_si[cmpf_pkg::FACE_TOP]    = l + SW'(margin(r_col, r_res[cmpf_pkg::FACE_TOP]));
        n_sj[cmpf_pkg::FACE_TOP]    = '0;
        n_si[cmpf_pkg::FACE_FRONT]  = l;
        n_sj[cmpf_pkg::FACE_FRONT]  = t + SW'(margin(r_band, r_res[cmpf_pkg::FACE_FRONT]));
        n_si[cmpf_pkg::FACE_BOTTOM] = l + SW'(margin(r_col, r_res[cmpf_pkg::FACE_BOTTOM]));
        n_sj[cmpf_pkg::FACE_BOTTOM] = t + b;
        n_si[cmpf_pkg::FACE_RIGHT]  = l + c;
        n_sj[cmpf_pkg::FACE_RIGHT]  = t + SW'(margin(r_band, r_res[cmpf_pkg::FACE_RIGHT]));
        n_si[cmpf_pkg::FACE_BACK]   = l + c + SW'(r_res[cmpf_pkg::FACE_RIGHT]);
        n_sj[cmpf_pkg::FACE_BACK]   = t + SW'(margin(r_band, r_res[cmpf_pkg::FACE_BACK]));
    end

    // starts are registered; input stalls for the cycle after a write
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 6; k++) begin
            r_si[k] <= n_si[k];
            r_sj[k] <= n_sj[k];
        end
    end

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            o_res[k*RES_BITS +: RES_BITS] = r_res[k];
            o_si[k*SW +: SW] = r_si[k];
            o_sj[k*SW +: SW] = r_sj[k];
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/cmpf_div.sv
// pipelined restoring divider: one quotient bit per stage, stall-aware
`default_nettype none
module cmpf_div #(
    parameter int NUM_W  = 16,
    parameter int DEN_W  = 13,
    parameter int QUO_W  = 16,
    parameter int TAG_W  = 3
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_adv,
    input  wire logic             i_valid,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    input  wire logic [TAG_W-1:0] i_tag,
    output logic                  o_valid,
    output logic [QUO_W-1:0]      o_quo,
    output logic [TAG_W-1:0]      o_tag
);
    // remainder stays below den, so DEN_W+1 bits hold it; the trial adds a sign bit
    localparam int RW = DEN_W + 1;

    logic             r_v   [QUO_W+1];
    logic [RW-1:0]    r_rem [QUO_W+1];
    logic [DEN_W-1:0] r_den [QUO_W+1];
    logic [QUO_W-1:0] r_q   [QUO_W+1];
    logic [TAG_W-1:0] r_tag [QUO_W+1];

    // numerator is below den, so it is the first remainder
    always_comb begin
        r_v[0]   = i_valid;
        r_rem[0] = RW'(i_num);
        r_den[0] = i_den;
        r_q[0]   = '0;
        r_tag[0] = i_tag;
    end

    for (genvar s = 0; s < QUO_W; s++) begin : g_st
        logic [RW:0] w_sh;
        logic [RW:0] w_df;
        // numerator is off << QUO_W, so only zeros shift in
        always_comb begin
            w_sh  = {r_rem[s], 1'b0};
            w_df  = w_sh - {2'b0, r_den[s]};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v[s+1] <= 1'b0;
            else if (i_adv) r_v[s+1] <= r_v[s];
        end
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem[s+1] <= w_df[RW] ? w_sh[RW-1:0] : w_df[RW-1:0];
                r_q[s+1]   <= {r_q[s][QUO_W-2:0], ~w_df[RW]};
                r_den[s+1] <= r_den[s];
                r_tag[s+1] <= r_tag[s];
            end
        end
    end

    assign o_valid = r_v[QUO_W];
    assign o_quo   = r_q[QUO_W];
    assign o_tag   = r_tag[QUO_W];
endmodule
`default_nettype wire

>>> rtl/core/cube_map_pixel_to_face_unit.sv
// top level of the cube map pixel to face unit
`default_nettype none
// Maps one packed cube-map pixel coordinate per clock, while not stalled, to
// its face code and a Q0.FRAC_BITS offset inside the face. The pipeline takes
// a request every cycle unless o_stall is high. It has one stage for the face
// search, one for the offset, then one quotient bit per stage in each of the two
// restoring dividers. i_stall from the consumer freezes the whole pipeline
// while a result is held and is passed back as o_stall. Configuration writes
// are always ready; the face starts settle in the cycle after a write, and
// o_stall is high for that cycle. Write only while no request is in flight.
module cube_map_pixel_to_face_unit #(
    parameter int COORD_BITS = cmpf_pkg::COORD_BITS,
    parameter int RES_BITS   = cmpf_pkg::RES_BITS,
    parameter int FRAC_BITS  = cmpf_pkg::FRAC_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [COORD_BITS-1:0] i_pixel_i,
    input  wire logic [COORD_BITS-1:0] i_pixel_j,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [cmpf_pkg::FACE_BITS-1:0] o_face_code,
    output logic [cmpf_pkg::OUT_BITS-1:0]  o_norm_u,
    output logic [cmpf_pkg::OUT_BITS-1:0]  o_norm_v,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [cmpf_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [RES_BITS-1:0]   i_cfg_data
);
    localparam int SW = RES_BITS + 2;
    localparam int EW = (COORD_BITS > SW ? COORD_BITS : SW) + 1;
    localparam int FB = cmpf_pkg::FACE_BITS;

    logic [6*RES_BITS-1:0] w_res;
    logic [6*SW-1:0] w_si, w_sj;
    logic w_adv;
    logic w_busy;

    cmpf_geom #(.RES_BITS(RES_BITS)) u_geom (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data), .o_busy(w_busy),
        .o_res(w_res), .o_si(w_si), .o_sj(w_sj)
    );

    // output register holds; whole pipe advances unless result is held
    assign w_adv   = !(o_valid && i_stall);
    assign o_stall = !w_adv || w_busy;

    // stage 1: face search
    logic [5:0] w_hit;
    logic [FB-1:0] n_face;
    logic r1_v;
    logic [FB-1:0] r1_face;
    logic [COORD_BITS-1:0] r1_pi, r1_pj;

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            logic [EW-1:0] p, q, s, t, r;
            p = EW'(i_pixel_i);
            q = EW'(i_pixel_j);
            s = EW'(w_si[k*SW +: SW]);
            t = EW'(w_sj[k*SW +: SW]);
            r = EW'(w_res[k*RES_BITS +: RES_BITS]);
            w_hit[k] = (p >= s) && (p < s + r) && (q >= t) && (q < t + r);
        end
        priority if (w_hit[cmpf_pkg::FACE_LEFT])   n_face = cmpf_pkg::FACE_LEFT;
        else if (w_hit[cmpf_pkg::FACE_TOP])        n_face = cmpf_pkg::FACE_TOP;
        else if (w_hit[cmpf_pkg::FACE_FRONT])      n_face = cmpf_pkg::FACE_FRONT;
        else if (w_hit[cmpf_pkg::FACE_BOTTOM])     n_face = cmpf_pkg::FACE_BOTTOM;
        else if (w_hit[cmpf_pkg::FACE_RIGHT])      n_face = cmpf_pkg::FACE_RIGHT;
        else if (w_hit[cmpf_pkg::FACE_BACK])       n_face = cmpf_pkg::FACE_BACK;
        else                                        n_face = cmpf_pkg::FACE_NONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (w_adv) r1_v <= i_valid && !w_busy;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_face <= n_face;
            r1_pi   <= i_pixel_i;
            r1_pj   <= i_pixel_j;
        end
    end

    // stage 2: offsets and divisor select
    logic r2_v;
    logic [FB-1:0] r2_face;
    logic [RES_BITS-1:0] r2_ou, r2_ov, r2_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (w_adv) r2_v <= r1_v;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_face <= r1_face;
            if (r1_face == cmpf_pkg::FACE_NONE) begin
                r2_ou  <= '0;
                r2_ov  <= '0;
                r2_den <= RES_BITS'(1);
            end else begin
                // offset is below res, so it fits in RES_BITS
                r2_ou  <= RES_BITS'(EW'(r1_pi) - EW'(w_si[r1_face*SW +: SW]));
                r2_ov  <= RES_BITS'(EW'(r1_pj) - EW'(w_sj[r1_face*SW +: SW]));
                r2_den <= w_res[r1_face*RES_BITS +: RES_BITS];
            end
        end
    end

    logic w_du_v, w_dv_v;
    logic [FRAC_BITS-1:0] w_qu, w_qv;
    logic [FB-1:0] w_face_u, w_face_v;

    cmpf_div #(.NUM_W(RES_BITS), .DEN_W(RES_BITS), .QUO_W(FRAC_BITS), .TAG_W(FB)) u_div_u (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(w_adv),
        .i_valid(r2_v), .i_num(r2_ou), .i_den(r2_den), .i_tag(r2_face),
        .o_valid(w_du_v), .o_quo(w_qu), .o_tag(w_face_u)
    );
    cmpf_div #(.NUM_W(RES_BITS), .DEN_W(RES_BITS), .QUO_W(FRAC_BITS), .TAG_W(FB)) u_div_v (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(w_adv),
        .i_valid(r2_v), .i_num(r2_ov), .i_den(r2_den), .i_tag(r2_face),
        .o_valid(w_dv_v), .o_quo(w_qv), .o_tag(w_face_v)
    );

    assign o_valid     = w_du_v;
    assign o_face_code = w_face_u;
    assign o_norm_u    = cmpf_pkg::OUT_BITS'(w_qu);
    assign o_norm_v    = cmpf_pkg::OUT_BITS'(w_qv);

`ifndef SYNTH
    a_lanes_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_du_v == w_dv_v) && (!w_du_v || w_face_u == w_face_v))
        else $error("divider lanes out of step");
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_face_code == cmpf_pkg::FACE_NONE) |-> (o_norm_u == '0 && o_norm_v == '0))
        else $error("no-face result with nonzero coordinates");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_norm_u) && $stable(o_face_code)))
        else $error("held result changed");
`endif
endmodule
`default_nettype wire
